// ----- rtl/mdsm_pkg.sv -----
// shared types, codes and widths for the motor duty/speed mapper
// no dependencies
`default_nettype none
package mdsm_pkg;

	localparam int DUTY_ONE = 16384;
	localparam int AW = 33;        // multiplicand magnitude
	localparam int BW = 26;        // multiplier magnitude
	localparam int CW = 33;        // divisor magnitude
	localparam int QW = AW + BW;   // product and quotient width
	localparam int MW = QW + 2;    // signed width of the map result

	localparam logic [3:0] CMD_SET_DUTY  = 4'd0;
	localparam logic [3:0] CMD_SET_SPEED = 4'd1;
	localparam logic [3:0] CMD_ENABLE    = 4'd2;
	localparam logic [3:0] CMD_DISABLE   = 4'd3;
	localparam logic [3:0] CMD_STOP      = 4'd4;
	localparam logic [3:0] CMD_FULL_NEG  = 4'd5;
	localparam logic [3:0] CMD_FULL_POS  = 4'd6;
	localparam logic [3:0] CMD_MAP_SCALE = 4'd7;
	localparam logic [3:0] CMD_MAP_RANGE = 4'd8;
	localparam logic [3:0] CMD_REFRESH   = 4'd10;

	localparam logic [1:0] REG_DIR   = 2'd0;
	localparam logic [1:0] REG_SCALE = 2'd1;
	localparam logic [1:0] REG_ZP    = 2'd2;
	localparam logic [1:0] REG_DZ    = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAP,
		ST_CONV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic          start;
		logic [AW-1:0] a;
		logic [BW-1:0] b;
		logic [CW-1:0] c;
	} md_req_t;

endpackage
`default_nettype wire

// ----- rtl/mdsm_muldiv.sv -----
// shared unit: unsigned a*b/c, the product registered on start, then one quotient bit a cycle
// depends on mdsm_pkg
`default_nettype none
module mdsm_muldiv import mdsm_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire md_req_t       req,
	output logic               done,
	output logic [QW-1:0]      quot
);

	localparam int CNTW = $clog2(QW);
	localparam logic [CNTW-1:0] LAST = CNTW'(QW - 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [QW-1:0]   num_q;
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   div_q;
	logic [CW:0]     trial;
	logic            fits;

	always_comb begin
		trial = {rem_q, num_q[QW-1]};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST)
					busy_q <= 1'b0;
			end
		end
	end

	// dividend shifts out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= QW'(req.a * req.b);
			rem_q <= '0;
			div_q <= req.c;
		end else if (busy_q) begin
			num_q <= {num_q[QW-2:0], fits};
			rem_q <= fits ? CW'(trial - {1'b0, div_q}) : trial[CW-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule
`default_nettype wire

// ----- rtl/motor_duty_speed_mapper_core.sv -----
// motor duty/speed mapper: stored duty, speed and enable with command items
// depends on mdsm_pkg and mdsm_muldiv
//
// use: one command item on the input channel (in_valid/in_stall) gives one
// result item on the output channel (out_valid/out_stall). config writes go
// through cfg_write/cfg_index/cfg_data while the block is idle.
// sequence: enable, disable, query and zero-span map items go from accept
// straight to the output state. set duty, set speed, stop, full and refresh
// items run one pass of the shared multiply/divide unit. map items run two
// passes, map then speed-to-duty. each pass is a start, the product, the QW
// quotient bits and a done in the radix-2 divider, which sets the rate.
// one item is at work at a time; in_stall is high while it runs.
// the output register holds a result until taken, so a new item may be
// accepted while the receiver stalls; its result then waits in the sequencer.
// reset: duty and speed zero, disabled, registers to their defaults
// (scale 65536, no reversal, zeropoint and deadzone zero), channels empty.
`default_nettype none
module motor_duty_speed_mapper_core import mdsm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [23:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [3:0]         command,
	input  wire logic signed [31:0] value,
	input  wire logic signed [31:0] in_min,
	input  wire logic signed [31:0] in_max,
	input  wire logic signed [24:0] out_min,
	input  wire logic signed [24:0] out_max,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      output_duty,
	output logic                    output_valid,
	output logic signed [15:0]      duty_readback,
	output logic signed [24:0]      speed_readback,
	output logic                    span_error
);

	state_t state_q, state_nx;

	logic        dir_q;
	logic [23:0] scale_q;
	logic [13:0] zp_q;
	logic [14:0] dz_q;

	logic signed [15:0] duty_q;
	logic signed [24:0] speed_q;
	logic               en_q;
	logic               span_q;

	logic               to_speed_q;
	logic               neg_q;
	logic               zero_q;
	logic signed [25:0] omin_q;
	logic               md_start_q;
	logic [AW-1:0]      md_a_q;
	logic [BW-1:0]      md_b_q;
	logic [CW-1:0]      md_c_q;
	md_req_t            md_req;
	logic               md_done;
	logic [QW-1:0]      md_quot;

	logic               out_valid_q;
	logic signed [15:0] od_q;
	logic               ov_q;
	logic signed [15:0] dr_q;
	logic signed [24:0] sr_q;
	logic               se_q;

	logic               accept;
	logic               load_out;

	// datapath signals
	logic [23:0]        sc;
	logic [14:0]        span;
	logic [14:0]        dz_eff;
	logic signed [32:0] d_src;
	logic signed [32:0] d_rev;
	logic signed [15:0] d_cl;
	logic signed [15:0] dc_in;
	logic [14:0]        dc_mag;
	logic signed [MW-1:0] map_val;
	logic signed [MW-1:0] s_src;
	logic signed [MW-1:0] s_rev;
	logic signed [MW-1:0] sc_s;
	logic signed [24:0]   s_cl;
	logic [23:0]          s_mag;
	logic signed [32:0]   den;
	logic signed [32:0]   xl;
	logic signed [25:0]   omin_new;
	logic signed [25:0]   odiff;
	logic [14:0]          duty_mag;
	logic [QW-1:0]        q_plus;
	logic                 is_duty_cmd;
	logic                 is_map_cmd;

	always_comb begin
		md_req = '{start: md_start_q, a: md_a_q, b: md_b_q, c: md_c_q};
	end

	mdsm_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.done   (md_done),
		.quot   (md_quot)
	);

	always_comb begin
		sc     = (scale_q == '0) ? 24'd1 : scale_q;
		span   = 15'(DUTY_ONE) - {1'b0, zp_q};
		dz_eff = (dz_q > 15'(DUTY_ONE)) ? 15'(DUTY_ONE) : dz_q;

		unique case (command)
			CMD_STOP:     d_src = '0;
			CMD_FULL_NEG: d_src = -33'sd16384;
			CMD_FULL_POS: d_src = 33'sd16384;
			default:      d_src = 33'(value);
		endcase
		d_rev = dir_q ? -d_src : d_src;
		if (d_rev > 33'sd16384)
			d_cl = 16'sd16384;
		else if (d_rev < -33'sd16384)
			d_cl = -16'sd16384;
		else
			d_cl = d_rev[15:0];

		// duty to speed operand: refresh works on the stored duty
		dc_in  = (state_q == ST_IDLE && command == CMD_REFRESH) ? duty_q : d_cl;
		dc_mag = dc_in[15] ? 15'(-dc_in) : dc_in[14:0];

		// map result, then treated as a speed command
		map_val = (neg_q ? -$signed({2'b00, md_quot}) : $signed({2'b00, md_quot}))
			+ MW'(omin_q);
		s_src = (state_q == ST_MAP) ? map_val : MW'(value);
		s_rev = dir_q ? -s_src : s_src;
		sc_s  = $signed({{(MW-24){1'b0}}, sc});
		if (s_rev > sc_s)
			s_cl = 25'(sc_s);
		else if (s_rev < -sc_s)
			s_cl = 25'(-sc_s);
		else
			s_cl = s_rev[24:0];
		s_mag = s_cl[24] ? 24'(-s_cl) : s_cl[23:0];

		den      = 33'(in_max) - 33'(in_min);
		xl       = 33'(value) - 33'(in_min);
		omin_new = (command == CMD_MAP_SCALE) ? -$signed({2'b00, sc}) : 26'(out_min);
		odiff    = ((command == CMD_MAP_SCALE) ? $signed({2'b00, sc}) : 26'(out_max))
			- omin_new;

		duty_mag = duty_q[15] ? 15'(-duty_q) : duty_q[14:0];
		q_plus   = md_quot + QW'(zp_q);

		is_duty_cmd = command == CMD_SET_DUTY || command == CMD_STOP
			|| command == CMD_FULL_NEG || command == CMD_FULL_POS
			|| command == CMD_REFRESH;
		is_map_cmd = command == CMD_MAP_SCALE || command == CMD_MAP_RANGE;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_duty_cmd || command == CMD_SET_SPEED)
						state_nx = ST_CONV;
					else if (is_map_cmd && den != '0)
						state_nx = ST_MAP;
					else
						state_nx = ST_OUT;
				end
			end
			ST_MAP:  if (md_done) state_nx = ST_CONV;
			ST_CONV: if (md_done) state_nx = ST_OUT;
			ST_OUT:  if (load_out) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall = state_q != ST_IDLE;
		accept   = in_valid && !in_stall;
		load_out = state_q == ST_OUT && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dir_q       <= 1'b0;
			scale_q     <= 24'd65536;
			zp_q        <= '0;
			dz_q        <= '0;
			duty_q      <= '0;
			speed_q     <= '0;
			en_q        <= 1'b0;
			out_valid_q <= 1'b0;
			md_start_q  <= 1'b0;
		end else begin
			state_q    <= state_nx;
			md_start_q <= 1'b0;
			if (cfg_write) begin
				unique case (cfg_index)
					REG_DIR:   dir_q   <= cfg_data[0];
					REG_SCALE: scale_q <= cfg_data;
					REG_ZP:    zp_q    <= cfg_data[13:0];
					REG_DZ:    dz_q    <= cfg_data[14:0];
					default:   ;
				endcase
			end

			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			priority case (1'b1)
				accept: begin
					if (is_duty_cmd) begin
						if (command != CMD_REFRESH) begin
							duty_q <= d_cl;
							en_q   <= 1'b1;
						end
						md_start_q <= 1'b1;
					end else if (command == CMD_SET_SPEED) begin
						speed_q    <= s_cl;
						en_q       <= 1'b1;
						md_start_q <= 1'b1;
					end else if (is_map_cmd) begin
						md_start_q <= den != '0;
					end else if (command == CMD_ENABLE) begin
						en_q <= 1'b1;
					end else if (command == CMD_DISABLE) begin
						en_q <= 1'b0;
					end
				end
				(state_q == ST_MAP && md_done): begin
					speed_q    <= s_cl;
					en_q       <= 1'b1;
					md_start_q <= 1'b1;
				end
				(state_q == ST_CONV && md_done): begin
					if (to_speed_q)
						speed_q <= neg_q ? -$signed(25'(md_quot)) : $signed(25'(md_quot));
					else if (zero_q)
						duty_q <= '0;
					else
						duty_q <= neg_q ? -$signed(16'(q_plus)) : $signed(16'(q_plus));
				end
				default: ;
			endcase
		end
	end

	// operands of the shared unit and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			span_q <= is_map_cmd && den == '0;
			omin_q <= omin_new;
			if (is_duty_cmd) begin
				to_speed_q <= 1'b1;
				neg_q      <= dc_in[15];
				md_a_q     <= AW'((dc_mag > 15'(zp_q)) ? dc_mag - 15'(zp_q) : 15'd0);
				md_b_q     <= BW'(sc);
				md_c_q     <= CW'(span);
			end else if (command == CMD_SET_SPEED) begin
				to_speed_q <= 1'b0;
				neg_q      <= s_cl[24];
				zero_q     <= s_cl == '0;
				md_a_q     <= AW'(s_mag);
				md_b_q     <= BW'(span);
				md_c_q     <= CW'(sc);
			end else begin
				neg_q  <= xl[32] ^ odiff[25] ^ den[32];
				md_a_q <= xl[32] ? AW'(-xl) : AW'(xl);
				md_b_q <= odiff[25] ? BW'(-odiff) : BW'(odiff);
				md_c_q <= den[32] ? CW'(-den) : CW'(den);
			end
		end else if (state_q == ST_MAP && md_done) begin
			to_speed_q <= 1'b0;
			neg_q      <= s_cl[24];
			zero_q     <= s_cl == '0;
			md_a_q     <= AW'(s_mag);
			md_b_q     <= BW'(span);
			md_c_q     <= CW'(sc);
		end
		if (load_out) begin
			od_q <= (en_q && duty_mag >= dz_eff) ? duty_q : '0;
			ov_q <= en_q;
			dr_q <= dir_q ? -duty_q : duty_q;
			sr_q <= dir_q ? -speed_q : speed_q;
			se_q <= span_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign output_duty    = od_q;
	assign output_valid   = ov_q;
	assign duty_readback  = dr_q;
	assign speed_readback = sr_q;
	assign span_error     = se_q;

	// the shared unit only finishes while the sequencer waits on it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q == ST_MAP || state_q == ST_CONV))
		else $error("divider finished outside a wait state");

	// a disabled result never drives a duty
	a_duty_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (output_valid || output_duty == '0))
		else $error("duty driven while disabled");

	// stored duty stays within plus and minus one
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> (duty_q <= 16'sd16384 && duty_q >= -16'sd16384))
		else $error("stored duty out of range");

endmodule
`default_nettype wire

// ----- test/motor_duty_speed_mapper_core_tb.sv -----
// testbench for motor_duty_speed_mapper_core: random and directed command items
// checked against a behavioural predictor of duty, speed and enable state
// depends on mdsm_pkg and the core rtl
`timescale 1ns / 1ps
module motor_duty_speed_mapper_core_tb import mdsm_pkg::*;;

	localparam logic [3:0] CMD_QUERY = 4'd9;
	localparam int LIMIT = 1000000;
	localparam int DRAIN = 300;

	typedef struct {
		logic [3:0]         cmd;
		logic signed [31:0] val;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic signed [24:0] omin;
		logic signed [24:0] omax;
	} cmd_item_t;

	typedef struct {
		logic signed [15:0] duty;
		logic               ovalid;
		logic signed [15:0] duty_rb;
		logic signed [24:0] speed_rb;
		logic               serr;
	} motor_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [1:0] cfg_index = REG_DIR;
	logic [23:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] command = CMD_QUERY;
	logic signed [31:0] value = '0, in_min = '0, in_max = '0;
	logic signed [24:0] out_min = '0, out_max = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] output_duty, duty_readback;
	logic output_valid, span_error;
	logic signed [24:0] speed_readback;

	motor_duty_speed_mapper_core u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state and register copies
	longint pr_duty, pr_speed;
	bit pr_enabled;
	bit reg_rev;
	longint reg_scale, reg_zp, reg_dz;

	cmd_item_t pending_items[$];
	motor_result_t expected_results[$];
	int errors = 0, checked = 0, span_hits = 0;
	longint cycles = 0;
	bit quiet = 1'b0;

	function automatic longint eff_scale();
		return reg_scale == 0 ? 1 : reg_scale;
	endfunction

	function automatic longint speed_of_duty(longint d);
		longint den;
		den = DUTY_ONE - reg_zp;
		if (d > reg_zp) return (d - reg_zp) * eff_scale() / den;
		if (d < -reg_zp) return -((-d - reg_zp) * eff_scale() / den);
		return 0;
	endfunction

	function automatic longint duty_of_speed(longint s);
		longint span;
		span = DUTY_ONE - reg_zp;
		if (s > 0) return s * span / eff_scale() + reg_zp;
		if (s < 0) return -((-s) * span / eff_scale() + reg_zp);
		return 0;
	endfunction

	function automatic void command_duty(longint d);
		if (reg_rev) d = -d;
		pr_duty = d < -DUTY_ONE ? -DUTY_ONE : (d > DUTY_ONE ? DUTY_ONE : d);
		pr_speed = speed_of_duty(pr_duty);
		pr_enabled = 1'b1;
	endfunction

	function automatic void command_speed(longint s);
		longint sc;
		sc = eff_scale();
		if (reg_rev) s = -s;
		pr_speed = s < -sc ? -sc : (s > sc ? sc : s);
		pr_duty = duty_of_speed(pr_speed);
		pr_enabled = 1'b1;
	endfunction

	// returns 1 on zero span, state untouched then
	function automatic bit map_to_speed(longint x, longint lo, longint hi,
			longint omin, longint omax);
		if (hi == lo) return 1'b1;
		command_speed((x - lo) * (omax - omin) / (hi - lo) + omin);
		return 1'b0;
	endfunction

	function automatic motor_result_t apply_command(cmd_item_t it);
		motor_result_t r;
		bit serr;
		longint dz;
		serr = 1'b0;
		case (it.cmd)
			CMD_SET_DUTY:  command_duty(it.val);
			CMD_SET_SPEED: command_speed(it.val);
			CMD_ENABLE:    pr_enabled = 1'b1;
			CMD_DISABLE:   pr_enabled = 1'b0;
			CMD_STOP:      command_duty(0);
			CMD_FULL_NEG:  command_duty(-DUTY_ONE);
			CMD_FULL_POS:  command_duty(DUTY_ONE);
			CMD_MAP_SCALE: serr = map_to_speed(it.val, it.lo, it.hi, -eff_scale(), eff_scale());
			CMD_MAP_RANGE: serr = map_to_speed(it.val, it.lo, it.hi, it.omin, it.omax);
			CMD_REFRESH:   pr_speed = speed_of_duty(pr_duty);
			default: ;
		endcase
		dz = reg_dz > DUTY_ONE ? DUTY_ONE : reg_dz;
		r.duty = (pr_enabled && (pr_duty <= -dz || pr_duty >= dz)) ? 16'(pr_duty) : '0;
		r.ovalid = pr_enabled;
		r.duty_rb = 16'(reg_rev ? -pr_duty : pr_duty);
		r.speed_rb = 25'(reg_rev ? -pr_speed : pr_speed);
		r.serr = serr;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, checked);
		errors++;
	endtask

	// driver
	bit taken = 1'b0;
	int in_gap = 0, out_gap = 0;
	always @(negedge clk) begin
		cmd_item_t it;
		if (arst_n && (!in_valid || taken)) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				command <= it.cmd;
				value <= it.val;
				in_min <= it.lo;
				in_max <= it.hi;
				out_min <= it.omin;
				out_max <= it.omax;
				in_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 14);
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_gap = $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		cmd_item_t it;
		motor_result_t w;
		taken = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			taken = 1'b1;
			it.cmd = command; it.val = value; it.lo = in_min; it.hi = in_max;
			it.omin = out_min; it.omax = out_max;
			expected_results.push_back(apply_command(it));
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("unexpected result item");
				errors++;
			end else begin
				w = expected_results.pop_front();
				if (output_duty !== w.duty) report_mismatch("output_duty", output_duty, w.duty);
				if (output_valid !== w.ovalid)
					report_mismatch("output_valid", output_valid, w.ovalid);
				if (duty_readback !== w.duty_rb)
					report_mismatch("duty_readback", duty_readback, w.duty_rb);
				if (speed_readback !== w.speed_rb)
					report_mismatch("speed_readback", speed_readback, w.speed_rb);
				if (span_error !== w.serr) report_mismatch("span_error", span_error, w.serr);
				if (w.serr) span_hits++;
				checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("motor_duty_speed_mapper_core_tb NOT OK");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [23:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_DIR:   reg_rev = data[0];
			REG_SCALE: reg_scale = data;
			REG_ZP:    reg_zp = data[13:0];
			REG_DZ:    reg_dz = data[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_regs(logic rev, logic [23:0] sc, logic [13:0] zp, logic [14:0] dz);
		write_reg(REG_DIR, {23'd0, rev});
		write_reg(REG_SCALE, sc);
		write_reg(REG_ZP, {10'd0, zp});
		write_reg(REG_DZ, {9'd0, dz});
	endtask

	task automatic queue_cmd(logic [3:0] c, logic signed [31:0] v,
			logic signed [31:0] lo = 0, logic signed [31:0] hi = 32'sh10000,
			logic signed [24:0] omin = 0, logic signed [24:0] omax = 0);
		cmd_item_t it;
		it.cmd = c; it.val = v; it.lo = lo; it.hi = hi; it.omin = omin; it.omax = omax;
		pending_items.push_back(it);
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 40000)) - 20000;
		endcase
	endfunction

	task automatic queue_random(int n);
		logic signed [31:0] lo, hi, x;
		logic [3:0] c;
		repeat (n) begin
			c = 4'($urandom_range(0, 15));
			if (c == CMD_MAP_SCALE || c == CMD_MAP_RANGE) begin
				if ($urandom_range(0, 4) == 0) begin
					lo = $urandom; hi = $urandom; x = $urandom;
				end else begin
					lo = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
					hi = $urandom_range(0, 7) == 0 ? lo : lo + $signed($urandom_range(1, 1 << 20));
					x = lo + $signed($urandom_range(0, 1 << 21)) - (1 << 19);
				end
				queue_cmd(c, x, lo, hi, 25'($urandom), 25'($urandom));
			end else if (c == CMD_SET_SPEED) begin
				queue_cmd(c, $urandom_range(0, 3) == 0 ? $urandom
					: 32'($signed($urandom_range(0, 2 * eff_scale() + 2)) - eff_scale() - 1));
			end else begin
				queue_cmd(c, rand_word(), $urandom, $urandom, 25'($urandom), 25'($urandom));
			end
		end
	endtask

	initial begin
		reg_rev = 1'b0; reg_scale = 65536; reg_zp = 0; reg_dz = 0;
		pr_duty = 0; pr_speed = 0; pr_enabled = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset state, every command, field extremes, zero span
		queue_cmd(CMD_QUERY, 0);
		queue_cmd(CMD_SET_DUTY, 32'sh7fffffff);
		queue_cmd(CMD_SET_DUTY, 32'sh80000000);
		queue_cmd(CMD_DISABLE, 0);
		queue_cmd(CMD_SET_SPEED, 32'sh7fffffff);
		queue_cmd(CMD_SET_SPEED, 32'sh80000000);
		queue_cmd(CMD_SET_SPEED, 0);
		queue_cmd(CMD_FULL_NEG, 0);
		queue_cmd(CMD_FULL_POS, 0);
		queue_cmd(CMD_STOP, 0);
		queue_cmd(CMD_ENABLE, 0);
		queue_cmd(CMD_MAP_SCALE, 32'sh8000, 0, 32'sh10000);
		queue_cmd(CMD_MAP_SCALE, 5, 7, 7);
		queue_cmd(CMD_MAP_RANGE, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			-25'sd16777216, 25'sd16777215);
		queue_cmd(CMD_MAP_RANGE, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			25'sd16777215, -25'sd16777216);
		queue_cmd(CMD_MAP_RANGE, 1, 32'sh80000000, 32'sh80000000, 1, 2);
		queue_cmd(CMD_SET_DUTY, 1000);
		queue_cmd(CMD_REFRESH, 0);
		queue_cmd(4'd11, 0);
		queue_cmd(4'd15, 32'sh7fffffff);
		wait_idle();

		set_regs(1'b1, 24'hffffff, 14'd16383, 15'd16384);
		queue_cmd(CMD_SET_DUTY, 16384);
		queue_cmd(CMD_SET_SPEED, -100);
		queue_cmd(CMD_REFRESH, 0);
		queue_random(130);
		wait_idle();

		set_regs(1'b0, 24'd0, 14'd8192, 15'h7fff);
		queue_cmd(CMD_SET_DUTY, 9000);
		queue_cmd(CMD_SET_SPEED, 1);
		queue_random(130);
		wait_idle();

		// registers alone do not move stored speed; refresh does
		set_regs(1'b0, 24'd1, 14'd0, 15'd100);
		queue_cmd(CMD_REFRESH, 0);
		queue_random(130);
		wait_idle();

		repeat (4) begin
			set_regs(1'($urandom_range(0, 1)),
				24'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1 << 18)),
				14'($urandom), 15'($urandom));
			queue_random(140);
			wait_idle();
		end

		quiet = 1'b1;
		set_regs(1'b0, 24'd65536, 14'd2000, 15'd3000);
		queue_random(120);
		wait_idle();

		repeat (DRAIN) @(posedge clk);
		$display("checked %0d result items over %0d cycles, %0d zero-span maps",
			checked, cycles, span_hits);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("motor_duty_speed_mapper_core_tb OK");
		end else begin
			$display("%0d mismatches, %0d results outstanding", errors, expected_results.size());
			$display("motor_duty_speed_mapper_core_tb NOT OK");
		end
		$finish;
	end

endmodule

// ----- motor_duty_speed_mapper_core.f -----
rtl/mdsm_pkg.sv
rtl/mdsm_muldiv.sv
rtl/motor_duty_speed_mapper_core.sv
test/motor_duty_speed_mapper_core_tb.sv
